>>> src/bra_pkg.sv
// Shared types, constants and helper functions of the bitmap run allocator.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    // Map geometry
    localparam int NBITS   = 1024;
    localparam int WORD_W  = 32;
    localparam int OFS_W   = $clog2(WORD_W);
    localparam int N_WORDS = (NBITS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = $clog2(N_WORDS);

    // Field widths
    localparam int OP_W   = 3;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int SIZE_W = 11;
    localparam int SUM_W  = CNT_W + 1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SET       = 3'd0;
    localparam logic [OP_W-1:0] OP_CLR       = 3'd1;
    localparam logic [OP_W-1:0] OP_FLIP      = 3'd2;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd3;
    localparam logic [OP_W-1:0] OP_RANGE     = 3'd4;
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd5;
    localparam logic [OP_W-1:0] OP_SCAN_FLIP = 3'd6;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic             value;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] found_index;
        logic             bit_value;
    } t_out_item;

    // Position of the lowest set bit (0 when none is set)
    function automatic logic [OFS_W-1:0] f_lowest(input t_word v);
        logic [OFS_W-1:0] pos;
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                pos = OFS_W'(j);
            end
        end
        return pos;
    endfunction

    // Position of the highest set bit (0 when none is set)
    function automatic logic [OFS_W-1:0] f_highest(input t_word v);
        logic [OFS_W-1:0] pos;
        pos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (v[j]) begin
                pos = OFS_W'(j);
            end
        end
        return pos;
    endfunction

    // Mark each bit position where n consecutive set bits of m begin.
    // Builds runs of 1, 2, 4, ... by doubling and combines them per bit of n.
    function automatic t_word f_run_starts(input t_word m, input logic [OFS_W-1:0] n);
        t_word            acc;
        t_word            pw;
        logic [OFS_W-1:0] off;
        acc = '1;
        pw  = m;
        off = '0;
        for (int k = 0; k < OFS_W; k++) begin
            if (n[k]) begin
                acc = acc & (pw >> off);
                off = off + OFS_W'(1 << k);
            end
            pw = pw & (pw >> (1 << k));
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> src/bra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: sequencer, word RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

// A bit map of 1024 entries kept as 32 words of 32 bits in a RAM, with one valid
// flip-flop per word so that the whole map reads as zero right after reset (no
// clearing pass). One item is worked at a time; o_in_stall is high from accept
// until the result has been moved to the output register. Operations work the
// map one word at a time through a single mask and compare unit: set, clear and
// flip read, modify and write one word, test reads one word, a range set does
// so for each word it touches, a scan evaluates each word examined in two steps,
// and a scan-and-flip then inverts the run it found word by word. An item that
// touches nothing (single-bit write or scan at an index out of range, zero
// count, unused opcode) goes straight to the done state. A stalled output
// register holds the result in the done state. The pace is set by the one RAM
// read port and the two-step run evaluation per word. The bits_in_use register
// may be written at any time the block is idle.
module bitmap_run_allocator (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [bra_pkg::SIZE_W-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire bra_pkg::t_in_item        i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output bra_pkg::t_out_item            o_out_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RW   = 6'b000010,
        ST_TEST = 6'b000100,
        ST_SC_A = 6'b001000,
        ST_SC_B = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    localparam bra_pkg::t_word ONES = {bra_pkg::WORD_W{1'b1}};

    // Registers
    t_state                             r_state, n_state;
    logic [bra_pkg::SIZE_W-1:0]         r_bits_in_use;
    logic [bra_pkg::IDX_W-1:0]          r_lo, n_lo;
    logic [bra_pkg::IDX_W-1:0]          r_last, n_last;
    logic [bra_pkg::WADDR_W-1:0]        r_word, n_word;
    logic [bra_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [bra_pkg::SIZE_W-1:0]         r_run_start, n_run_start;
    logic                               r_val, n_val;
    logic                               r_xor, n_xor;
    logic                               r_flip, n_flip;
    logic                               r_hit, n_hit;
    bra_pkg::t_word                     r_m, n_m;
    bra_pkg::t_word                     r_win, n_win;
    bra_pkg::t_out_item                 r_res, n_res;
    bra_pkg::t_out_item                 r_out, n_out;
    logic                               r_out_valid, n_out_valid;
    logic [bra_pkg::N_WORDS-1:0]        r_wvalid;
    logic                               r_rd_vld;

    // RAM controls and combinational values
    logic                               ram_we;
    logic [bra_pkg::WADDR_W-1:0]        ram_waddr;
    bra_pkg::t_word                     ram_wdata;
    logic                               ram_re;
    logic [bra_pkg::WADDR_W-1:0]        ram_raddr;
    bra_pkg::t_word                     ram_rdata;

    logic [bra_pkg::SIZE_W-1:0]         size;
    logic [bra_pkg::SIZE_W-1:0]         size_m1;
    logic                               idx_ok;
    logic [bra_pkg::SUM_W-1:0]          hi_sum;
    logic [bra_pkg::SUM_W-1:0]          hi_end;
    bra_pkg::t_word                     rd_word;
    bra_pkg::t_word                     lo_mask;
    bra_pkg::t_word                     hi_mask;
    bra_pkg::t_word                     word_mask;
    bra_pkg::t_word                     match;
    logic [bra_pkg::SUM_W-1:0]          base_w;
    logic [bra_pkg::OFS_W:0]            first_zero;
    logic                               carried_ok;
    logic                               short_ok;
    logic [bra_pkg::SUM_W-1:0]          start;
    logic                               out_take;

    // Effective map size and bounds of a new item
    assign size    = (r_bits_in_use > bra_pkg::SIZE_W'(bra_pkg::NBITS))
                   ? bra_pkg::SIZE_W'(bra_pkg::NBITS) : r_bits_in_use;
    assign size_m1 = size - bra_pkg::SIZE_W'(1);
    assign idx_ok  = bra_pkg::SIZE_W'(i_in_data.index) < size;
    assign hi_sum  = bra_pkg::SUM_W'(i_in_data.index) + bra_pkg::SUM_W'(i_in_data.count);
    assign hi_end  = (hi_sum > bra_pkg::SUM_W'(size)) ? bra_pkg::SUM_W'(size) : hi_sum;

    // Shared word mask: bits of the current word within [r_lo, r_last]
    assign rd_word   = r_rd_vld ? ram_rdata : '0;
    assign lo_mask   = (r_word == r_lo[bra_pkg::OFS_W +: bra_pkg::WADDR_W])
                     ? (ONES << r_lo[bra_pkg::OFS_W-1:0]) : ONES;
    assign hi_mask   = (r_word == r_last[bra_pkg::OFS_W +: bra_pkg::WADDR_W])
                     ? (ONES >> (bra_pkg::OFS_W'(bra_pkg::WORD_W - 1)
                                 - r_last[bra_pkg::OFS_W-1:0]))
                     : ONES;
    assign word_mask = lo_mask & hi_mask;
    assign match     = ~(rd_word ^ {bra_pkg::WORD_W{r_val}}) & word_mask;

    // Run evaluation on the registered match vector
    assign base_w     = bra_pkg::SUM_W'({r_word, {bra_pkg::OFS_W{1'b0}}});
    assign first_zero = (&r_m) ? (bra_pkg::OFS_W + 1)'(bra_pkg::WORD_W)
                               : (bra_pkg::OFS_W + 1)'(bra_pkg::f_lowest(~r_m));
    assign carried_ok = (bra_pkg::SUM_W'(r_run_start) + bra_pkg::SUM_W'(r_cnt))
                        <= (base_w + bra_pkg::SUM_W'(first_zero));
    assign short_ok   = (r_cnt < bra_pkg::CNT_W'(bra_pkg::WORD_W)) && (r_win != '0);
    assign start      = carried_ok ? bra_pkg::SUM_W'(r_run_start)
                                   : base_w + bra_pkg::SUM_W'(bra_pkg::f_lowest(r_win));

    assign out_take = r_out_valid && !i_out_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_last      = r_last;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_run_start = r_run_start;
        n_val       = r_val;
        n_xor       = r_xor;
        n_flip      = r_flip;
        n_hit       = r_hit;
        n_m         = r_m;
        n_win       = r_win;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_word;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = i_in_data.index[bra_pkg::OFS_W +: bra_pkg::WADDR_W];

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res  = '0;
                    n_lo   = i_in_data.index;
                    n_last = i_in_data.index;
                    n_word = i_in_data.index[bra_pkg::OFS_W +: bra_pkg::WADDR_W];
                    n_val  = i_in_data.value;
                    n_cnt  = i_in_data.count;
                    n_xor  = 1'b0;
                    n_flip = 1'b0;
                    n_hit  = idx_ok;
                    n_state = ST_DONE;
                    case (i_in_data.opcode)
                        bra_pkg::OP_SET, bra_pkg::OP_CLR, bra_pkg::OP_FLIP: begin
                            n_xor = (i_in_data.opcode == bra_pkg::OP_FLIP);
                            n_val = (i_in_data.opcode == bra_pkg::OP_SET);
                            if (idx_ok) begin
                                ram_re  = 1'b1;
                                n_state = ST_RW;
                            end
                        end
                        bra_pkg::OP_TEST: begin
                            ram_re  = 1'b1;
                            n_state = ST_TEST;
                        end
                        bra_pkg::OP_RANGE: begin
                            n_last = bra_pkg::IDX_W'(hi_end - bra_pkg::SUM_W'(1));
                            if (idx_ok && (i_in_data.count != '0)) begin
                                ram_re  = 1'b1;
                                n_state = ST_RW;
                            end
                        end
                        bra_pkg::OP_SCAN, bra_pkg::OP_SCAN_FLIP: begin
                            n_res.status = 1'b1;
                            n_flip       = (i_in_data.opcode == bra_pkg::OP_SCAN_FLIP);
                            n_last       = size_m1[bra_pkg::IDX_W-1:0];
                            n_run_start  = bra_pkg::SIZE_W'({
                                i_in_data.index[bra_pkg::OFS_W +: bra_pkg::WADDR_W],
                                {bra_pkg::OFS_W{1'b0}}});
                            if (idx_ok && (i_in_data.count != '0)) begin
                                ram_re  = 1'b1;
                                n_state = ST_SC_A;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            // Read-modify-write one word per cycle, prefetch the next one
            ST_RW: begin
                ram_we    = 1'b1;
                ram_waddr = r_word;
                if (r_xor) begin
                    ram_wdata = rd_word ^ word_mask;
                end else if (r_val) begin
                    ram_wdata = rd_word | word_mask;
                end else begin
                    ram_wdata = rd_word & ~word_mask;
                end
                if (r_word == r_last[bra_pkg::OFS_W +: bra_pkg::WADDR_W]) begin
                    n_state = ST_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_word + bra_pkg::WADDR_W'(1);
                    n_word    = r_word + bra_pkg::WADDR_W'(1);
                end
            end

            ST_TEST: begin
                n_res.bit_value = r_hit & rd_word[r_lo[bra_pkg::OFS_W-1:0]];
                n_state         = ST_DONE;
            end

            // Build the match vector and its run starts, prefetch the next word
            ST_SC_A: begin
                n_m   = match;
                n_win = bra_pkg::f_run_starts(match, r_cnt[bra_pkg::OFS_W-1:0]);
                if (r_word != r_last[bra_pkg::OFS_W +: bra_pkg::WADDR_W]) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_word + bra_pkg::WADDR_W'(1);
                end
                n_state = ST_SC_B;
            end

            // Decide on this word: found, failed, or carry the open run
            ST_SC_B: begin
                if (carried_ok || short_ok) begin
                    n_res.status      = 1'b0;
                    n_res.found_index = start[bra_pkg::IDX_W-1:0];
                    if (r_flip) begin
                        n_lo      = start[bra_pkg::IDX_W-1:0];
                        n_last    = bra_pkg::IDX_W'(start + bra_pkg::SUM_W'(r_cnt)
                                                    - bra_pkg::SUM_W'(1));
                        n_word    = start[bra_pkg::OFS_W +: bra_pkg::WADDR_W];
                        n_xor     = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = start[bra_pkg::OFS_W +: bra_pkg::WADDR_W];
                        n_state   = ST_RW;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (r_word == r_last[bra_pkg::OFS_W +: bra_pkg::WADDR_W]) begin
                    n_state = ST_DONE;
                end else begin
                    if (!(&r_m)) begin
                        n_run_start = bra_pkg::SIZE_W'(base_w
                                      + bra_pkg::SUM_W'(bra_pkg::f_highest(~r_m))
                                      + bra_pkg::SUM_W'(1));
                    end
                    n_word  = r_word + bra_pkg::WADDR_W'(1);
                    n_state = ST_SC_A;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_bits_in_use <= bra_pkg::SIZE_W'(1024);
            r_out_valid   <= 1'b0;
            r_wvalid      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bits_in_use <= i_cfg_data;
            end
            if (ram_we) begin
                r_wvalid[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_last      <= n_last;
        r_word      <= n_word;
        r_cnt       <= n_cnt;
        r_run_start <= n_run_start;
        r_val       <= n_val;
        r_xor       <= n_xor;
        r_flip      <= n_flip;
        r_hit       <= n_hit;
        r_m         <= n_m;
        r_win       <= n_win;
        r_res       <= n_res;
        r_out       <= n_out;
        if (ram_re) begin
            r_rd_vld <= r_wvalid[ram_raddr];
        end
    end

    bra_ram #(
        .WIDTH (bra_pkg::WORD_W),
        .DEPTH (bra_pkg::N_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
